// File: hdl/rlete_pkg.sv
// Shared types, constants and helpers for the run-length threshold encoder.
package rlete_pkg;

  localparam int unsigned CODE_W     = 8;
  localparam int unsigned THR_W      = 6;
  localparam int unsigned COPY_W     = THR_W;
  localparam int unsigned SKIP_W     = 16;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [THR_W-1:0] THR_CAP = THR_W'(62);

  typedef enum logic [0:0] {
    REG_RUN_THRESHOLD = 1'b0,
    REG_SKIP_COUNT    = 1'b1
  } cfg_reg_t;

  // One run to expand: value repeated copies times, then an optional tail word.
  typedef struct packed {
    logic [CODE_W-1:0] value;
    logic [COPY_W-1:0] copies;
    logic              tail_en;
    logic [CODE_W-1:0] tail;
  } seg_t;

  // Work left by one element: up to two runs, emitted in order.
  typedef struct packed {
    seg_t seg_a;
    seg_t seg_b;
    logic stream_end;
  } job_t;

  localparam seg_t SEG_EMPTY = '{value: '0, copies: '0, tail_en: 1'b0, tail: '0};

  function automatic logic seg_live(seg_t s);
    return (s.copies != '0) || s.tail_en;
  endfunction

endpackage

// File: hdl/rlete_if.sv
// Channel interfaces: element input, code word output and register write port.
interface rlete_in_if;
  import rlete_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] element;
  logic              end_of_buffer;

  modport source (output valid, output element, output end_of_buffer, input ready);
  modport sink   (input valid, input element, input end_of_buffer, output ready);
endinterface

interface rlete_out_if;
  import rlete_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_word;
  logic              last_of_step;
  logic              stream_end;

  modport source (output valid, output code_word, output last_of_step, output stream_end,
                  input ready);
  modport sink   (input valid, input code_word, input last_of_step, input stream_end,
                  output ready);
endinterface

interface rlete_cfg_if;
  import rlete_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_reg_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/rlete_run_tracker.sv
// Run tracking state and per-element job builder.
module rlete_run_tracker #(
  parameter int unsigned ELEMENT_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [rlete_pkg::CODE_W-1:0]  element,
  input  logic                          end_of_buffer,
  input  logic [rlete_pkg::THR_W-1:0]   run_threshold,
  input  logic [rlete_pkg::SKIP_W-1:0]  skip_count,
  output logic                          push,
  output rlete_pkg::job_t               job,
  output logic                          run_idle
);
  import rlete_pkg::*;

  localparam int unsigned CntW = ((ELEMENT_BITS > CODE_W) ? ELEMENT_BITS : CODE_W) + 1;
  localparam logic [CODE_W-1:0] ElemMask = (ELEMENT_BITS >= CODE_W) ? {CODE_W{1'b1}} :
                                           CODE_W'((64'd1 << ELEMENT_BITS) - 64'd1);
  localparam logic [ELEMENT_BITS-1:0] RunMax = '1;

  logic [CODE_W-1:0]       prev_r, prev_nxt, prev_mid;
  logic [ELEMENT_BITS-1:0] len_r, len_nxt, len_mid;
  logic [SKIP_W-1:0]       pos_r, pos_nxt;
  logic [CODE_W-1:0]       elem_m;
  logic [THR_W-1:0]        thr_eff;
  logic                    pass, extend, brk;
  seg_t                    seg_a, seg_b;

  function automatic seg_t encode_run(logic [CODE_W-1:0] value,
                                      logic [ELEMENT_BITS-1:0] count,
                                      logic [THR_W-1:0] thr);
    logic [CntW-1:0] cnt_x;
    logic [CntW-1:0] thr_x;
    logic [CntW-1:0] diff;
    seg_t            s;
    cnt_x     = CntW'(count);
    thr_x     = CntW'(thr);
    diff      = cnt_x - thr_x;
    s.value   = value;
    s.copies  = (cnt_x < thr_x) ? cnt_x[COPY_W-1:0] : thr;
    s.tail_en = (cnt_x >= thr_x);
    s.tail    = diff[CODE_W-1:0] & ElemMask;
    return s;
  endfunction

  always_comb begin
    elem_m  = element & ElemMask;
    thr_eff = (run_threshold > THR_CAP) ? THR_CAP : run_threshold;
    // pass-through only before any element of this buffer was coded
    pass    = (len_r == '0) && (pos_r < skip_count);
    extend  = !pass && (elem_m == prev_r) && (len_r != RunMax);
    brk     = !pass && !extend;

    if (pass) begin
      seg_a = '{value: elem_m, copies: COPY_W'(1), tail_en: 1'b0, tail: '0};
    end else if (brk) begin
      seg_a = encode_run(prev_r, len_r, thr_eff);
    end else begin
      seg_a = SEG_EMPTY;
    end

    prev_mid = brk ? elem_m : prev_r;
    if (brk) begin
      len_mid = ELEMENT_BITS'(1);
    end else if (extend) begin
      len_mid = len_r + ELEMENT_BITS'(1);
    end else begin
      len_mid = len_r;
    end

    // flush the open run on the last element
    seg_b = end_of_buffer ? encode_run(prev_mid, len_mid, thr_eff) : SEG_EMPTY;

    job.seg_a      = seg_a;
    job.seg_b      = seg_b;
    job.stream_end = end_of_buffer;
    push           = accept && (seg_live(seg_a) || seg_live(seg_b));

    prev_nxt = prev_r;
    len_nxt  = len_r;
    pos_nxt  = pos_r;
    if (accept) begin
      if (end_of_buffer) begin
        prev_nxt = '0;
        len_nxt  = '0;
        pos_nxt  = '0;
      end else begin
        prev_nxt = prev_mid;
        len_nxt  = len_mid;
        pos_nxt  = (pos_r != {SKIP_W{1'b1}}) ? pos_r + SKIP_W'(1) : pos_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      len_r  <= '0;
      pos_r  <= '0;
    end else begin
      prev_r <= prev_nxt;
      len_r  <= len_nxt;
      pos_r  <= pos_nxt;
    end
  end

  assign run_idle = (len_r == '0) && (pos_r == '0) && (prev_r == '0);

endmodule

// File: hdl/rlete_emitter.sv
// Job register and output word register: expands runs into one word per cycle unless stalled.
module rlete_emitter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  rlete_pkg::job_t              job_in,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rlete_pkg::CODE_W-1:0] code_word,
  output logic                         last_of_step,
  output logic                         stream_end,
  output logic                         job_busy
);
  import rlete_pkg::*;

  logic              job_valid_r, job_valid_nxt;
  job_t              job_r, job_nxt, job_load;
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] word_r, word_nxt, word_cur;
  logic              last_r, last_nxt, last_cur;
  logic              end_r, end_nxt;
  logic              out_adv, emit, finish, seg_done;
  seg_t              seg_after;

  always_comb begin
    // move the second run forward when the first is empty
    job_load = job_in;
    if (!seg_live(job_in.seg_a)) begin
      job_load.seg_a = job_in.seg_b;
      job_load.seg_b = SEG_EMPTY;
    end

    out_adv = !out_valid_r || out_ready;
    emit    = job_valid_r && out_adv;

    seg_after = job_r.seg_a;
    if (job_r.seg_a.copies != '0) begin
      word_cur         = job_r.seg_a.value;
      seg_after.copies = job_r.seg_a.copies - COPY_W'(1);
    end else begin
      word_cur          = job_r.seg_a.tail;
      seg_after.tail_en = 1'b0;
    end
    seg_done = !seg_live(seg_after);
    last_cur = seg_done && !seg_live(job_r.seg_b);
    finish   = emit && last_cur;
    in_ready = !job_valid_r || finish;

    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    if (push) begin
      job_nxt       = job_load;
      job_valid_nxt = 1'b1;
    end else if (emit) begin
      if (seg_done) begin
        job_nxt.seg_a = job_r.seg_b;
        job_nxt.seg_b = SEG_EMPTY;
      end else begin
        job_nxt.seg_a = seg_after;
      end
      if (finish) begin
        job_valid_nxt = 1'b0;
      end
    end

    out_valid_nxt = out_adv ? emit : out_valid_r;
    word_nxt      = emit ? word_cur : word_r;
    last_nxt      = emit ? last_cur : last_r;
    end_nxt       = emit ? job_r.stream_end : end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    word_r <= word_nxt;
    last_r <= last_nxt;
    end_r  <= end_nxt;
  end

  assign out_valid    = out_valid_r;
  assign code_word    = word_r;
  assign last_of_step = last_r;
  assign stream_end   = end_r;
  assign job_busy     = job_valid_r;

endmodule

// File: hdl/rle_threshold_encoder.sv
// Top level of the run-length threshold encoder: registers, run tracker and emitter.
// Takes one element per cycle while elements only extend a run or need no output and no
// job is pending; every code word leaves through a single output register, one word per
// cycle while out_ch is ready. An element that ends a run (or a pass-through element, or
// the last element of a buffer) leaves a job of 1 to 64 words, and the input is held
// until the next-to-last word of that job has left. Its words pass through the job
// register and then the output register. Configuration is written through cfg_ch, which
// is always ready; write only while no job is in flight.
module rle_threshold_encoder #(
  parameter int unsigned ELEMENT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  rlete_in_if.sink    in_ch,
  rlete_out_if.source out_ch,
  rlete_cfg_if.sink   cfg_ch
);
  import rlete_pkg::*;

  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [SKIP_W-1:0] skip_r, skip_nxt;
  logic              in_accept, push, in_ready, job_busy, run_idle;
  job_t              job;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    thr_nxt  = thr_r;
    skip_nxt = skip_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_RUN_THRESHOLD: thr_nxt  = cfg_ch.data[THR_W-1:0];
        REG_SKIP_COUNT:    skip_nxt = cfg_ch.data[SKIP_W-1:0];
        default: begin
          thr_nxt  = thr_r;
          skip_nxt = skip_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_W'(2);
      skip_r <= '0;
    end else begin
      thr_r  <= thr_nxt;
      skip_r <= skip_nxt;
    end
  end

  assign in_ch.ready = in_ready;
  assign in_accept   = in_ch.valid && in_ready;

  rlete_run_tracker #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_tracker (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .element       (in_ch.element),
    .end_of_buffer (in_ch.end_of_buffer),
    .run_threshold (thr_r),
    .skip_count    (skip_r),
    .push          (push),
    .job           (job),
    .run_idle      (run_idle)
  );

  rlete_emitter u_emitter (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .job_in       (job),
    .in_ready     (in_ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .code_word    (out_ch.code_word),
    .last_of_step (out_ch.last_of_step),
    .stream_end   (out_ch.stream_end),
    .job_busy     (job_busy)
  );

`ifndef SYNTHESIS
  // state returns to its reset values after the last element of a buffer
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_ch.end_of_buffer |=> run_idle)
    else $error("run state not cleared after end of buffer");

  // a word that is not the last of its element always has more work behind it
  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last_of_step |-> job_busy)
    else $error("non-final word shown with no job pending");

  // words of one element follow each other without a gap
  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_of_step |=>
      out_ch.valid && (out_ch.stream_end == $past(out_ch.stream_end)))
    else $error("burst interrupted or stream_end changed within a burst");
`endif

endmodule
